// ===== src/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// spe_pkg
// types and constants shared by the shortest path engine
// ----------------------------------------------------------------------------
package spe_pkg;

    localparam int NODE_BITS = 4;
    localparam int MAX_NODES = 16;
    localparam int EDGE_BITS = 8;
    localparam int MAX_EDGES = 256;
    localparam int DIST_BITS = 20;
    localparam int W_BITS    = 16;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] ST_PATH    = 3'd0;
    localparam logic [2:0] ST_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_NO_PATH = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic [15:0] weight;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  path_node;
        logic [19:0] distance;
        logic        last;
    } t_out;

    typedef struct packed {
        logic                 we;
        logic [EDGE_BITS-1:0] waddr;
        logic [NODE_BITS-1:0] wstart;
        logic [NODE_BITS-1:0] wend;
        logic [W_BITS-1:0]    wcost;
        logic [EDGE_BITS-1:0] raddr;
    } t_edge_req;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN, S_EDGE_RD, S_EDGE, S_WALK, S_EMIT, S_SINGLE
    } t_state;

endpackage

// ===== src/spe_edge_mem.sv =====
// ----------------------------------------------------------------------------
// spe_edge_mem
// edge table memory, one write and one registered read port
// ----------------------------------------------------------------------------
module spe_edge_mem import spe_pkg::*; (
    input  logic                 i_clk,
    input  t_edge_req            i_req,
    output logic [NODE_BITS-1:0] o_start,
    output logic [NODE_BITS-1:0] o_end,
    output logic [W_BITS-1:0]    o_cost
);
    logic [NODE_BITS*2+W_BITS-1:0] r_mem [MAX_EDGES];
    logic [NODE_BITS*2+W_BITS-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= {i_req.wstart, i_req.wend, i_req.wcost};
        end
        r_rd <= r_mem[i_req.raddr];
    end

    assign {o_start, o_end, o_cost} = r_rd;
endmodule

// ===== src/shortest_path_engine.sv =====
// ----------------------------------------------------------------------------
// shortest_path_engine
// edge table with a single pair shortest path search
// add edge: accept or reject result. bad query: one bad status result. clear: no result.
// query: a node scan and a read of every edge table entry in each round, then
// one result per path node.
// synchronous active-low reset empties the table and sets node count to 16.
// ----------------------------------------------------------------------------
module shortest_path_engine import spe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);
    t_state r_state, n_state;
    logic [4:0]           r_n;
    logic [EDGE_BITS:0]   r_cnt;
    t_in                  r_in;
    logic [DIST_BITS-1:0] r_dist [MAX_NODES];
    logic [NODE_BITS:0]   r_pred [MAX_NODES];
    logic [NODE_BITS-1:0] r_stack [MAX_NODES];
    logic [MAX_NODES-1:0] r_reach, r_set;
    logic [NODE_BITS:0]   r_i, r_round;
    logic [NODE_BITS-1:0] r_u, r_cur;
    logic                 r_found;
    logic [EDGE_BITS:0]   r_e;
    logic [NODE_BITS:0]   r_sp;
    logic [NODE_BITS-1:0] r_k;
    logic                 r_ov;
    t_out                 r_out;

    t_edge_req            req;
    logic [NODE_BITS-1:0] e_start, e_end;
    logic [W_BITS-1:0]    e_cost;
    logic                 accept, out_free, ov_set;
    logic [DIST_BITS-1:0] cand;
    logic [NODE_BITS-1:0] ii;
    logic [EDGE_BITS-1:0] eidx;

    spe_edge_mem u_mem (.i_clk(i_clk), .i_req(req), .o_start(e_start), .o_end(e_end),
        .o_cost(e_cost));

    assign out_free = !r_ov || !i_stall;
    assign o_stall  = r_state != S_IDLE || !out_free;
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_ov;
    assign o_data   = r_out;
    assign ii       = r_i[NODE_BITS-1:0];
    assign eidx     = r_e[EDGE_BITS-1:0] - 1'b1;
    assign cand     = r_dist[r_u] + DIST_BITS'(e_cost);
    assign ov_set   = (accept && i_data.action == ACT_ADD)
                      || ((r_state == S_EMIT || r_state == S_SINGLE) && out_free);

    always_comb begin
        req.we     = accept && i_data.action == ACT_ADD && i_data.from_node < r_n
                     && i_data.to_node < r_n && r_cnt < (EDGE_BITS+1)'(MAX_EDGES);
        req.waddr  = r_cnt[EDGE_BITS-1:0];
        req.wstart = i_data.from_node;
        req.wend   = i_data.to_node;
        req.wcost  = i_data.weight;
        req.raddr  = eidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_data.action == ACT_QUERY) begin
                    n_state = (i_data.from_node >= r_n || i_data.to_node >= r_n)
                              ? S_SINGLE : S_INIT;
                end
            end
            S_INIT:    n_state = (r_n > 5'd1) ? S_SCAN : S_WALK;
            S_SCAN: begin
                if ({1'b0, r_i} == {1'b0, r_n} - 1'b1 || r_i == r_n) begin
                    n_state = S_SCAN;
                end
                if (r_i == r_n) begin
                    n_state = !r_found ? S_WALK : (r_cnt == '0 ? S_EDGE : S_EDGE_RD);
                end
            end
            S_EDGE_RD: n_state = S_EDGE;
            S_EDGE: begin
                if (r_e == '0 || r_e == 9'd1) begin
                    n_state = ({1'b0, r_round} + 6'd2 >= {1'b0, r_n}) ? S_WALK : S_SCAN;
                end else begin
                    n_state = S_EDGE_RD;
                end
            end
            S_WALK: begin
                if (!r_reach[r_in.to_node]) begin
                    n_state = S_SINGLE;
                end else if (r_sp + 1'b1 >= r_n || r_pred[r_cur][NODE_BITS]) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT:   if (out_free && r_k == '0) n_state = S_IDLE;
            S_SINGLE: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= 5'd16;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_n <= (i_cfg_data == 5'd0) ? 5'd1 : (i_cfg_data > 5'd16 ? 5'd16 : i_cfg_data);
            end
            r_ov <= ov_set || (r_ov && i_stall);
            if (accept) begin
                r_in <= i_data;
                if (i_data.action == ACT_CLEAR) r_cnt <= '0;
                if (i_data.action == ACT_ADD) begin
                    r_out <= '{status: req.we ? ST_ACCEPT : ST_REJECT, path_node: '0,
                               distance: '0, last: 1'b1};
                    if (req.we) r_cnt <= r_cnt + 1'b1;
                end
                if (i_data.action == ACT_QUERY) begin
                    r_out <= '{status: ST_BAD, path_node: '0, distance: '0, last: 1'b1};
                end
            end
            case (r_state)
                S_INIT: begin
                    r_reach <= MAX_NODES'(1) << r_in.from_node;
                    r_set   <= '0;
                    for (int j = 0; j < MAX_NODES; j++) begin
                        r_pred[j] <= '1;
                        r_dist[j] <= '0;
                    end
                    r_round <= '0; r_i <= '0; r_found <= 1'b0;
                    r_sp <= '0; r_cur <= r_in.to_node;
                end
                S_SCAN: begin
                    if (r_i == r_n) begin
                        r_i <= '0;
                        if (r_found) r_set[r_u] <= 1'b1;
                        r_e <= r_cnt;
                    end else begin
                        if (!r_set[ii] && r_reach[ii] && (!r_found || r_dist[ii] < r_dist[r_u]))
                        begin
                            r_u <= ii; r_found <= 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EDGE_RD: ;
                S_EDGE: begin
                    if (r_e != '0) begin
                        if (e_start == r_u && {1'b0, e_end} < r_n && !r_set[e_end]
                            && (!r_reach[e_end] || cand < r_dist[e_end])) begin
                            r_dist[e_end]  <= cand;
                            r_reach[e_end] <= 1'b1;
                            r_pred[e_end]  <= {1'b0, r_u};
                        end
                        r_e <= r_e - 1'b1;
                    end
                    if (r_e == '0 || r_e == 9'd1) begin
                        r_round <= r_round + 1'b1; r_found <= 1'b0;
                    end
                end
                S_WALK: begin
                    if (!r_reach[r_in.to_node]) begin
                        r_out <= '{status: ST_NO_PATH, path_node: '0, distance: '0, last: 1'b1};
                    end else begin
                        r_stack[r_sp[NODE_BITS-1:0]] <= r_cur;
                        r_sp <= r_sp + 1'b1;
                        r_cur <= r_pred[r_cur][NODE_BITS-1:0];
                        r_k <= r_sp[NODE_BITS-1:0];
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out <= '{status: ST_PATH, path_node: r_stack[r_k],
                                   distance: r_dist[r_in.to_node], last: r_k == '0};
                        r_k   <= r_k - 1'b1;
                    end
                end
                S_SINGLE: ;
                default: ;
            endcase
        end
    end
endmodule
